[rtl/core/eusd_pkg.sv]
// eusd_pkg: shared types and constants of the encoder unwrap and stall detector
// depends on nothing
`default_nettype none
package eusd_pkg;

  // motion state machine
  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_POWERED = 2'd1,
    ST_BLOCKED = 2'd2
  } motion_state_e;

  // configuration register indexes
  localparam logic [1:0] CFG_DRIVE_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_HOLD_COUNT      = 2'd1;
  localparam logic [1:0] CFG_STALL_GAIN      = 2'd2;

  // configuration reset values
  localparam logic [6:0]  DRIVE_THRESHOLD_RST = 7'd16;
  localparam logic [7:0]  HOLD_COUNT_RST      = 8'd25;
  localparam logic [15:0] STALL_GAIN_RST      = 16'd1024;

  // raw encoder counter geometry
  localparam int RAW_WIDTH  = 12;
  localparam int WRAP_STEP  = 4096;
  localparam int HALF_RANGE = 2048;

  // speed test: |delta| below this many bits may count as slow
  localparam int SLOW_BITS  = 24;
  localparam int SPEED_SHIFT = 8;

endpackage
`default_nettype wire

[rtl/core/encoder_unwrap_stall_detector.sv]
// encoder_unwrap_stall_detector: two-axis counter extension, window delta and stall fsm
// depends on eusd_pkg; history ring is a one-port synchronous memory in this module
// pipeline: a result passes two register stages, stage one and the output register,
//   before it is offered; a stall on the result channel can hold it in stage one
// throughput: one request per cycle while the result channel does not stall, set by
//   the accept-stage count recurrence and one read-before-write ring access per request
// reset: counts, ring pointer and hold counter cleared, state stopped, registers to
//   their defaults; ring entries read as zero through per-entry valid bits, no sweep
`default_nettype none
module encoder_unwrap_stall_detector
  import eusd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 10,
  parameter int COUNT_WIDTH   = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [23:0]        encoder_frame_i,
  input  wire logic signed [7:0]  drive_value_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      first_axis_count_o,
  output logic signed [31:0]      second_axis_count_o,
  output logic signed [31:0]      window_delta_o,
  output logic signed [7:0]       gated_drive_o,
  output logic                    stalled_o
);

  localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int XW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
  localparam int CW = COUNT_WIDTH;

  // extend a count across a wrap of its raw low bits
  function automatic logic [CW-1:0] unwrap(input logic [CW-1:0] cnt,
                                           input logic [RAW_WIDTH-1:0] raw);
    logic signed [RAW_WIDTH:0] diff;
    logic [CW-1:0] res;
    diff = $signed({1'b0, raw}) - $signed({1'b0, cnt[RAW_WIDTH-1:0]});
    res  = cnt;
    if (diff < -(RAW_WIDTH+1)'(HALF_RANGE)) res = res + CW'(WRAP_STEP);
    if (diff > (RAW_WIDTH+1)'(HALF_RANGE))  res = res - CW'(WRAP_STEP);
    return {res[CW-1:RAW_WIDTH], raw};
  endfunction

  // configuration registers
  logic [6:0]  drive_threshold_q;
  logic [7:0]  hold_count_q;
  logic [15:0] stall_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_threshold_q <= DRIVE_THRESHOLD_RST;
      hold_count_q      <= HOLD_COUNT_RST;
      stall_gain_q      <= STALL_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DRIVE_THRESHOLD: drive_threshold_q <= cfg_wdata_i[6:0];
        CFG_HOLD_COUNT:      hold_count_q      <= cfg_wdata_i[7:0];
        CFG_STALL_GAIN:      stall_gain_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid_q, out_valid_q;
  logic out_free, s1_free, s1_move, in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_accept  = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_q  <= in_valid_i;
      if (out_free) out_valid_q <= s1_valid_q;
    end
  end

  // accept stage: count recurrence and ring pointer
  logic [CW-1:0] first_q, first_d, second_q, second_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [7:0]    mag;
  logic [23:0]   prod;

  assign first_d  = unwrap(first_q, encoder_frame_i[RAW_WIDTH-1:0]);
  assign second_d = unwrap(second_q, encoder_frame_i[2*RAW_WIDTH-1:RAW_WIDTH]);
  assign ptr_d    = (ptr_q == PW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + PW'(1);
  assign mag      = drive_value_i[7] ? (8'd0 - drive_value_i) : drive_value_i;
  assign prod     = mag * stall_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      ptr_q    <= '0;
    end else if (in_accept) begin
      first_q  <= first_d;
      second_q <= second_d;
      ptr_q    <= ptr_d;
    end
  end

  // history ring: read old entry and write new count at the same address
  logic [CW-1:0]            hist_mem [HISTORY_DEPTH];
  logic [CW-1:0]            hist_rd_q;
  logic [HISTORY_DEPTH-1:0] hist_vld_q;
  logic                     hist_ok_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hist_rd_q       <= hist_mem[ptr_q];
      hist_mem[ptr_q] <= first_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      hist_ok_q  <= 1'b0;
    end else if (in_accept) begin
      hist_ok_q         <= hist_vld_q[ptr_q];
      hist_vld_q[ptr_q] <= 1'b1;
    end
  end

  // stage one payload
  logic [CW-1:0] s1_first_q, s1_second_q;
  logic [23:0]   s1_prod_q;
  logic          s1_powered_q;
  logic [7:0]    s1_drive_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_first_q   <= first_d;
      s1_second_q  <= second_d;
      s1_prod_q    <= prod;
      s1_powered_q <= (mag >= {1'b0, drive_threshold_q});
      s1_drive_q   <= drive_value_i;
    end
  end

  // window delta and speed test
  logic [CW-1:0] delta, abs_delta;
  logic [XW-1:0] abs_x;
  logic          slow;

  assign delta     = s1_first_q - (hist_ok_q ? hist_rd_q : '0);
  assign abs_delta = delta[CW-1] ? (CW'(0) - delta) : delta;
  assign abs_x     = XW'(abs_delta);
  assign slow      = (abs_x[XW-1:SLOW_BITS] == '0) &&
                     ({abs_x[SLOW_BITS-1:0], SPEED_SHIFT'(0)} < {8'd0, s1_prod_q});

  // motion state machine with hold counter
  motion_state_e state_q, state_d;
  logic [7:0]    hold_q, hold_d;
  logic          hold_hit;

  assign hold_hit = (hold_q == hold_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STOPPED;
      hold_q  <= '0;
    end else if (s1_move) begin
      state_q <= state_d;
      hold_q  <= hold_d;
    end
  end

  always_comb begin
    state_d = state_q;
    hold_d  = hold_q;
    case (state_q)
      ST_POWERED: begin
        if (!s1_powered_q || slow) begin
          hold_d = hold_hit ? 8'd0 : hold_q + 8'd1;
          if (hold_hit) state_d = s1_powered_q ? ST_BLOCKED : ST_STOPPED;
        end else begin
          hold_d = 8'd0;
        end
      end
      ST_BLOCKED: begin
        if (!s1_powered_q) begin
          hold_d = hold_hit ? 8'd0 : hold_q + 8'd1;
          if (hold_hit) state_d = ST_STOPPED;
        end
      end
      default: begin
        state_d = ST_STOPPED;
        if (s1_powered_q) begin
          hold_d  = 8'd0;
          state_d = ST_POWERED;
        end
      end
    endcase
  end

  // output register
  logic [31:0] out_first_q, out_second_q, out_delta_q;
  logic [7:0]  out_drive_q;
  logic        out_stalled_q;
  logic        blocked_d;

  assign blocked_d = (state_d == ST_BLOCKED);

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_first_q   <= 32'(XW'(s1_first_q));
      out_second_q  <= 32'(XW'(s1_second_q));
      out_delta_q   <= 32'(XW'(delta));
      out_drive_q   <= blocked_d ? 8'd0 : s1_drive_q;
      out_stalled_q <= blocked_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign first_axis_count_o  = out_first_q;
  assign second_axis_count_o = out_second_q;
  assign window_delta_o      = out_delta_q;
  assign gated_drive_o       = out_drive_q;
  assign stalled_o           = out_stalled_q;

endmodule
`default_nettype wire

[rtl/core/eusd_checker.sv]
// eusd_checker: port-level assertions for the encoder unwrap and stall detector
// depends on nothing; bound to the top level below
`default_nettype none
module eusd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] first_axis_count_o,
  input wire logic signed [31:0] second_axis_count_o,
  input wire logic signed [31:0] window_delta_o,
  input wire logic signed [7:0]  gated_drive_o,
  input wire logic               stalled_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(first_axis_count_o) &&
    $stable(second_axis_count_o) && $stable(window_delta_o) &&
    $stable(gated_drive_o) && $stable(stalled_o))
    else $error("result payload changed while stalled");

  // drive is gated off while blocked
  a_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stalled_o |-> gated_drive_o == 8'sd0)
    else $error("drive passed while stalled");

  // no back-pressure on requests while the output slot is empty
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with empty output");

endmodule

bind encoder_unwrap_stall_detector eusd_checker u_eusd_checker (.*);
`default_nettype wire

[dv/encoder_unwrap_stall_detector_tb.sv]
`timescale 1ns / 1ps
// encoder_unwrap_stall_detector_tb: self-checking bench with its own unwrap and stall fsm model
// depends on eusd_pkg and encoder_unwrap_stall_detector; random request gaps and result stalls
module encoder_unwrap_stall_detector_tb;
  import eusd_pkg::*;

  localparam int HIST        = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 300;

  // one result as the block presents it
  typedef struct packed {
    logic signed [31:0] first_count;
    logic signed [31:0] second_count;
    logic signed [31:0] delta;
    logic signed [7:0]  drive;
    logic               stalled;
  } eusd_result_t;

  // model of the counts, window ring and motion fsm plus the queue of expected results
  class stall_scoreboard;
    logic [6:0]    thr;
    logic [7:0]    hold_cfg;
    logic [15:0]   gain;
    logic [31:0]   first_count;
    logic [31:0]   second_count;
    logic [31:0]   ring [HIST];
    int            ptr;
    motion_state_e mstate;
    logic [7:0]    hold_cnt;
    eusd_result_t  pending_q[$];
    int            errors, requests, results, blocked_seen, wraps, reg_writes;

    function new();
      thr          = DRIVE_THRESHOLD_RST;
      hold_cfg     = HOLD_COUNT_RST;
      gain         = STALL_GAIN_RST;
      first_count  = '0;
      second_count = '0;
      foreach (ring[i]) ring[i] = '0;
      ptr          = 0;
      mstate       = ST_STOPPED;
      hold_cnt     = '0;
      errors = 0; requests = 0; results = 0; blocked_seen = 0; wraps = 0; reg_writes = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      reg_writes++;
      case (idx)
        CFG_DRIVE_THRESHOLD: thr = data[6:0];
        CFG_HOLD_COUNT:      hold_cfg = data[7:0];
        CFG_STALL_GAIN:      gain = data;
        default: ;
      endcase
    endfunction

    // extend a 12-bit wrapping counter into the 32-bit count
    function logic [31:0] extend(logic [31:0] cnt, logic [11:0] raw);
      int diff;
      diff = int'({20'd0, raw}) - int'({20'd0, cnt[11:0]});
      if (diff < -HALF_RANGE) begin
        cnt = cnt + WRAP_STEP;
        wraps++;
      end
      if (diff > HALF_RANGE) begin
        cnt = cnt - WRAP_STEP;
        wraps++;
      end
      return {cnt[31:12], raw};
    endfunction

    // true when the hold counter has reached its setting; clears or advances it
    function bit hold_done();
      if (hold_cnt == hold_cfg) begin
        hold_cnt = '0;
        return 1'b1;
      end
      hold_cnt = hold_cnt + 8'd1;
      return 1'b0;
    endfunction

    function void note_request(logic [23:0] frame, logic [7:0] drv);
      logic [31:0]  delta, abs_d;
      logic [63:0]  lhs, rhs;
      logic [8:0]   mag;
      bit           slow, powered;
      eusd_result_t want;
      requests++;
      first_count = extend(first_count, frame[11:0]);
      delta = first_count - ring[ptr];
      ring[ptr] = first_count;
      ptr = (ptr + 1) % HIST;
      second_count = extend(second_count, frame[23:12]);

      // speed test against the drive, exact in integers
      abs_d = delta[31] ? -delta : delta;
      mag = drv[7] ? 9'd256 - {1'b0, drv} : {1'b0, drv};
      lhs = {32'd0, abs_d} << SPEED_SHIFT;
      rhs = {55'd0, mag} * {48'd0, gain};
      slow = ((abs_d >> SLOW_BITS) == 0) && (lhs < rhs);
      powered = mag >= {2'b00, thr};

      // motion fsm
      case (mstate)
        ST_POWERED: begin
          if (!powered) begin
            if (hold_done()) mstate = ST_STOPPED;
          end else if (slow) begin
            if (hold_done()) mstate = ST_BLOCKED;
          end else begin
            hold_cnt = '0;
          end
        end
        ST_BLOCKED: begin
          if (!powered) begin
            if (hold_done()) mstate = ST_STOPPED;
          end
        end
        default: begin
          mstate = ST_STOPPED;
          if (powered) begin
            hold_cnt = '0;
            mstate = ST_POWERED;
          end
        end
      endcase

      want.first_count  = first_count;
      want.second_count = second_count;
      want.delta        = delta;
      want.drive        = (mstate == ST_BLOCKED) ? 8'd0 : drv;
      want.stalled      = (mstate == ST_BLOCKED);
      pending_q.push_back(want);
    endfunction

    function void check_result(eusd_result_t got);
      eusd_result_t want;
      results++;
      if (got.stalled === 1'b1) blocked_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d arrived with nothing expected: count1 %0d count2 %0d",
                   results, got.first_count, got.second_count);
        return;
      end
      want = pending_q.pop_front();
      if (got.first_count !== want.first_count || got.second_count !== want.second_count ||
          got.delta !== want.delta || got.drive !== want.drive ||
          got.stalled !== want.stalled) begin
        errors++;
        if (errors <= 10)
          $display("result %0d mismatch: exp c1 %0d c2 %0d dlt %0d drv %0d stl %0b | got c1 %0d c2 %0d dlt %0d drv %0d stl %0b",
                   results, want.first_count, want.second_count, want.delta, want.drive,
                   want.stalled, got.first_count, got.second_count, got.delta, got.drive,
                   got.stalled);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [23:0]        encoder_frame_i = '0;
  logic signed [7:0]  drive_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] first_axis_count_o;
  logic signed [31:0] second_axis_count_o;
  logic signed [31:0] window_delta_o;
  logic signed [7:0]  gated_drive_o;
  logic               stalled_o;

  stall_scoreboard sb = new();
  bit   steady = 1'b0;
  logic long_hold = 1'b0;
  event long_hold_ev;
  int   cycle_cnt = 0;
  int   stall_left = 0;
  bit   stall_now = 1'b0;

  encoder_unwrap_stall_detector uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .encoder_frame_i     (encoder_frame_i),
    .drive_value_i       (drive_value_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .first_axis_count_o  (first_axis_count_o),
    .second_axis_count_o (second_axis_count_o),
    .window_delta_o      (window_delta_o),
    .gated_drive_o       (gated_drive_o),
    .stalled_o           (stalled_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("encoder_unwrap_stall_detector verification failed");
    $finish;
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    forever begin
      @(long_hold_ev);
      @(posedge clk_i);
      long_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk_i);
      long_hold <= 1'b0;
    end
  end

  // result side: take accepted results and pick the next stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result('{first_count: first_axis_count_o, second_count: second_axis_count_o,
                          delta: window_delta_o, drive: gated_drive_o, stalled: stalled_o});
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0, 1: begin
            stall_now  = 1'b0;
            stall_left = $urandom_range(1, 30);
          end
          2: begin
            stall_now  = 1'b1;
            stall_left = $urandom_range(1, 3);
          end
          default: begin
            stall_now  = 1'b1;
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(4, 12);
          end
        endcase
      end
      stall_left--;
      out_stall_i <= long_hold || stall_now;
    end
  end

  // offer one request, with a random gap first, and hold it until taken
  task automatic send_request(input logic [23:0] frame, input logic [7:0] drv);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (steady || r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    encoder_frame_i <= frame;
    drive_value_i   <= drv;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(frame, drv);
  endtask

  // stop offering and wait until every expected result is in
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [15:0] hold,
                            input logic [15:0] gain);
    write_reg(CFG_DRIVE_THRESHOLD, thr);
    write_reg(CFG_HOLD_COUNT, hold);
    write_reg(CFG_STALL_GAIN, gain);
  endtask

  // segments of steady drive and steady speed, with some noise frames
  task automatic run_phase(input int n_items, input bit with_pressure);
    int          seg_left;
    int          step;
    int          mag;
    logic [7:0]  seg_drive;
    logic [11:0] raw_a, raw_b;
    logic [23:0] frame;
    logic [7:0]  drv;
    int          r;
    seg_left  = 0;
    step      = 0;
    seg_drive = '0;
    raw_a     = sb.first_count[11:0];
    raw_b     = sb.second_count[11:0];
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (with_pressure && i == 40) -> long_hold_ev;
      if (with_pressure && i >= 40 && i < 140) steady = 1'b1;
      if (seg_left == 0) begin
        seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
                                               : $urandom_range(3, 40);
        r = $urandom_range(0, 99);
        if (r < 20) mag = (sb.thr == 0) ? 0 : $urandom_range(0, sb.thr - 1);
        else if (r < 80) mag = $urandom_range(sb.thr, 127);
        else if (r < 90) mag = 128;
        else mag = $urandom_range(0, 128);
        seg_drive = $urandom_range(0, 1) ? 8'(-mag) : 8'(mag);
        r = $urandom_range(0, 99);
        if (r < 40) step = $urandom_range(0, 3);
        else if (r < 70) step = $urandom_range(10, 80);
        else step = $urandom_range(150, 2047);
        if ($urandom_range(0, 1)) step = -step;
      end
      seg_left--;
      if ($urandom_range(0, 9) == 0) begin
        frame = 24'($urandom);
        drv   = 8'($urandom);
      end else begin
        raw_a = raw_a + 12'(step) + 12'($urandom_range(0, 2)) - 12'd1;
        raw_b = raw_b + 12'($urandom_range(0, 100)) - 12'd50;
        frame = {raw_b, raw_a};
        drv   = seg_drive;
      end
      send_request(frame, drv);
    end
    steady = 1'b0;
  endtask

  // main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: wraps at the half-range edges, drive extremes, fast stall entry
    write_reg(CFG_HOLD_COUNT, 16'd0);
    send_request(24'h000000, 8'd0);
    send_request(24'hFFFFFF, 8'd127);       // both axes wrap backward
    send_request(24'h000000, 8'd127);       // both wrap forward, no motion: blocked
    send_request(24'h000000, 8'(-127));
    send_request(24'h000000, 8'd15);        // just below threshold
    send_request(24'h000000, 8'd16);        // exactly at threshold
    send_request(24'h800800, 8'd16);        // jump of exactly half range
    send_request(24'h000000, 8'(-16));      // back by exactly half range
    send_request(24'h801801, 8'(-128));     // one past half range
    send_request(24'h000000, 8'(-128));
    send_request(24'h000FFF, 8'd127);
    send_request(24'hFFF000, 8'(-1));
    send_request(24'h555AAA, 8'd85);
    send_request(24'hAAA555, 8'(-86));
    settle();
    // zero threshold and zero gain: always powered, never slow
    set_config(16'd0, 16'd0, 16'd0);
    send_request(24'h123456, 8'd0);
    send_request(24'h123457, 8'd0);
    send_request(24'h654321, 8'd1);
    settle();
    // top threshold, top gain: only full drive is powered and always slow
    set_config(16'hFFFF, 16'd0, 16'hFFFF);
    send_request(24'h000000, 8'd127);
    send_request(24'h000000, 8'd127);
    send_request(24'h000001, 8'(-128));
    send_request(24'h000002, 8'd126);
    send_request(24'h000003, 8'd0);
    settle();

    // random phases over several register settings
    set_config({9'd0, DRIVE_THRESHOLD_RST}, {8'd0, HOLD_COUNT_RST}, STALL_GAIN_RST);
    run_phase(250, 1'b0);
    settle();
    set_config(16'd0, 16'd0, 16'hFFFF);
    run_phase(200, 1'b0);
    settle();
    set_config(16'd127, 16'd3, 16'd0);
    run_phase(200, 1'b0);
    settle();
    set_config(16'd40, 16'd255, 16'd4000);
    run_phase(300, 1'b0);
    settle();
    set_config(16'($urandom), 16'($urandom_range(0, 10)), 16'($urandom));
    run_phase(250, 1'b0);
    settle();
    set_config(16'd8, 16'd1, 16'd2048);
    run_phase(200, 1'b1);
    settle();

    if (sb.pending_q.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending_q.size());
      sb.errors += sb.pending_q.size();
    end
    $display("run covered %0d requests and %0d results over %0d register writes",
             sb.requests, sb.results, sb.reg_writes);
    $display("counter wrap corrections %0d, results in blocked state %0d, mismatches %0d",
             sb.wraps, sb.blocked_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("encoder_unwrap_stall_detector verification clean");
    end else begin
      $display("encoder_unwrap_stall_detector verification failed");
    end
    $finish;
  end

endmodule
